>>> hdl/ucp_pkg.sv
// Shared types and constants for the upsample-convolve pixel unit.
// Holds the request codes, the datapath control struct and the microcode ROM.
// No dependencies.
package ucp_pkg;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_COEF    = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    localparam int PIX_BITS = 16;

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE   = 3'd0;
    localparam step_t ST_START  = 3'd1;
    localparam step_t ST_TAP    = 3'd2;
    localparam step_t ST_DRAIN0 = 3'd3;
    localparam step_t ST_DRAIN1 = 3'd4;
    localparam step_t ST_FINISH = 3'd5;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_START,
        C_OOR,
        C_MORE_TAPS,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  acc_clear;
        logic  rd_en;
        logic  load_out;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    typedef struct packed {
        logic pix_we;
        logic coef_we;
        logic rd_en;
        logic acc_clear;
    } dp_ctrl_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t uc;
        uc = '{in_ready: 1'b1, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b0,
               cond: C_NO_START, jump: ST_IDLE, next: ST_START};
        unique case (step)
            ST_IDLE:
            begin
                uc = '{in_ready: 1'b1, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b0,
                       cond: C_NO_START, jump: ST_IDLE, next: ST_START};
            end
            ST_START:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b1, rd_en: 1'b0, load_out: 1'b0,
                       cond: C_OOR, jump: ST_FINISH, next: ST_TAP};
            end
            ST_TAP:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b0, rd_en: 1'b1, load_out: 1'b0,
                       cond: C_MORE_TAPS, jump: ST_TAP, next: ST_DRAIN0};
            end
            ST_DRAIN0:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b0,
                       cond: C_NEVER, jump: ST_IDLE, next: ST_DRAIN1};
            end
            ST_DRAIN1:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b0,
                       cond: C_NEVER, jump: ST_IDLE, next: ST_FINISH};
            end
            ST_FINISH:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b1,
                       cond: C_OUT_BUSY, jump: ST_FINISH, next: ST_IDLE};
            end
            default:
            begin
                uc = '{in_ready: 1'b0, acc_clear: 1'b0, rd_en: 1'b0, load_out: 1'b0,
                       cond: C_NEVER, jump: ST_IDLE, next: ST_IDLE};
            end
        endcase
        return uc;
    endfunction

endpackage

>>> hdl/upsample_convolve_pixel_unit.sv
// A compute item runs start, a tap read for each of the KERNEL_SIZE^2 taps, the drain
// steps DRAIN0 and DRAIN1, and finish, which registers the result and waits while the
// output is held; taps are read in turn through the single pixel store read port, and no
// new item is taken until back in idle. Write items are taken one per cycle while idle; a
// compute whose fallback pixel is off the image skips to finish. Reset sets both size
// registers to 128; the stores are undefined until written. Depends on ucp_pkg, ucp_datapath.
module upsample_convolve_pixel_unit
    import ucp_pkg::*;
#(
    parameter int MAX_SMALL_WIDTH = 128,
    parameter int MAX_SMALL_HEIGHT = 128,
    parameter int KERNEL_SIZE = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [7:0]         col,
    input  logic [7:0]         row,
    input  logic signed [15:0] red,
    input  logic signed [15:0] green,
    input  logic signed [15:0] blue,
    input  logic [4:0]         coef_index,
    input  logic [15:0]        coef_value,
    input  logic               subtract,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_red,
    output logic signed [15:0] out_green,
    output logic signed [15:0] out_blue,
    output logic               out_of_range,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int PIX_DEPTH = MAX_SMALL_WIDTH * MAX_SMALL_HEIGHT;
    localparam int AW = $clog2(PIX_DEPTH);
    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int TW = $clog2(TAPS);
    localparam int KW = $clog2(KERNEL_SIZE);
    localparam int HALF = KERNEL_SIZE / 2;

    step_t    step_reg;
    step_t    step_next;
    ucode_t   uc;
    logic     cond_true;
    dp_ctrl_t dp_ctrl;

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [7:0] eff_w;
    logic [7:0] eff_h;

    logic [7:0]            col_reg;
    logic [7:0]            row_reg;
    logic [3*PIX_BITS-1:0] ref_reg;
    logic                  sub_reg;

    logic [KW-1:0] tx_reg;
    logic [KW-1:0] ty_reg;
    logic [TW-1:0] tap_reg;

    logic          accept;
    logic          start;
    logic          out_busy;
    logic          oor;
    logic [7:0]    fx;
    logic [7:0]    fy;
    logic [9:0]    sx;
    logic [9:0]    sy;
    logic          tap_ok;
    logic [7:0]    rd_x;
    logic [7:0]    rd_y;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [3*PIX_BITS-1:0] result;

    logic                  out_valid_reg;
    logic [3*PIX_BITS-1:0] out_pix_reg;
    logic                  out_oor_reg;

    assign uc        = ucode_rom(step_reg);
    assign in_ready  = uc.in_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && uc.in_ready;
    assign start     = accept && (req_type == REQ_COMPUTE);
    assign out_busy  = out_valid_reg && !out_ready;

    always_comb
    begin
        if (width_reg == 8'd0)
        begin
            eff_w = 8'd1;
        end
        else if (32'(width_reg) > MAX_SMALL_WIDTH)
        begin
            eff_w = 8'(MAX_SMALL_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == 8'd0)
        begin
            eff_h = 8'd1;
        end
        else if (32'(height_reg) > MAX_SMALL_HEIGHT)
        begin
            eff_h = 8'(MAX_SMALL_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign fx  = {1'b0, col_reg[7:1]};
    assign fy  = {1'b0, row_reg[7:1]};
    assign oor = (fx >= eff_w) || (fy >= eff_h);

    assign sx = 10'(col_reg) + 10'(tx_reg) - 10'(HALF);
    assign sy = 10'(row_reg) + 10'(ty_reg) - 10'(HALF);
    assign tap_ok = !sx[9] && !sy[9] && (sx[8:1] < eff_w) && (sy[8:1] < eff_h);
    assign rd_x = tap_ok ? sx[8:1] : fx;
    assign rd_y = tap_ok ? sy[8:1] : fy;
    assign rd_addr = AW'(rd_y) * AW'(MAX_SMALL_WIDTH) + AW'(rd_x);
    assign wr_addr = AW'(row) * AW'(MAX_SMALL_WIDTH) + AW'(col);

    always_comb
    begin
        case (uc.cond)
            C_NO_START:  cond_true = !start;
            C_OOR:       cond_true = oor;
            C_MORE_TAPS: cond_true = (tap_reg != TW'(TAPS - 1));
            C_OUT_BUSY:  cond_true = out_busy;
            default:     cond_true = 1'b0;
        endcase
        step_next = cond_true ? uc.jump : uc.next;
    end

    always_comb
    begin
        dp_ctrl.pix_we    = accept && (req_type == REQ_PIXEL)
                            && (col < eff_w) && (row < eff_h);
        dp_ctrl.coef_we   = accept && (req_type == REQ_COEF) && (32'(coef_index) < TAPS);
        dp_ctrl.rd_en     = uc.rd_en;
        dp_ctrl.acc_clear = uc.acc_clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ST_IDLE;
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_valid)
            begin
                if (cfg_index)
                begin
                    height_reg <= cfg_data;
                end
                else
                begin
                    width_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            col_reg <= col;
            row_reg <= row;
            ref_reg <= {red, green, blue};
            sub_reg <= subtract;
        end
        if (uc.acc_clear)
        begin
            tx_reg  <= '0;
            ty_reg  <= '0;
            tap_reg <= '0;
        end
        else if (uc.rd_en)
        begin
            tap_reg <= tap_reg + TW'(1);
            if (tx_reg == KW'(KERNEL_SIZE - 1))
            begin
                tx_reg <= '0;
                ty_reg <= ty_reg + KW'(1);
            end
            else
            begin
                tx_reg <= tx_reg + KW'(1);
            end
        end
    end

    ucp_datapath #(
        .PIX_DEPTH(PIX_DEPTH),
        .TAPS     (TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .wr_addr   (wr_addr),
        .wr_pixel  ({red, green, blue}),
        .coef_waddr(TW'(coef_index)),
        .coef_wdata(coef_value),
        .rd_addr   (rd_addr),
        .coef_raddr(tap_reg),
        .ref_pixel (ref_reg),
        .sub       (sub_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uc.load_out && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.load_out && !out_busy)
        begin
            out_pix_reg <= oor ? '0 : result;
            out_oor_reg <= oor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg[3*PIX_BITS-1:2*PIX_BITS];
    assign out_green    = out_pix_reg[2*PIX_BITS-1:PIX_BITS];
    assign out_blue     = out_pix_reg[PIX_BITS-1:0];
    assign out_of_range = out_oor_reg;

endmodule

>>> hdl/ucp_datapath.sv
// Datapath of the upsample-convolve pixel unit: pixel and coefficient stores,
// three multiply-accumulate lanes and the final rounding and saturation.
// Depends on ucp_pkg.
module ucp_datapath
    import ucp_pkg::*;
#(
    parameter int PIX_DEPTH = 16384,
    parameter int TAPS = 25,
    localparam int AW = $clog2(PIX_DEPTH),
    localparam int TW = $clog2(TAPS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_ctrl_t              ctrl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [3*PIX_BITS-1:0] wr_pixel,
    input  logic [TW-1:0]         coef_waddr,
    input  logic [15:0]           coef_wdata,
    input  logic [AW-1:0]         rd_addr,
    input  logic [TW-1:0]         coef_raddr,
    input  logic [3*PIX_BITS-1:0] ref_pixel,
    input  logic                  sub,
    output logic [3*PIX_BITS-1:0] result
);

    localparam int ACC_W = 33 + TW;
    localparam int RW = ACC_W + 1;
    localparam int QW = RW - 16;

    logic [3*PIX_BITS-1:0] pix_mem [PIX_DEPTH];
    logic [15:0]           coef_mem [TAPS];

    logic [3*PIX_BITS-1:0] pix_rd_reg;
    logic [15:0]           coef_rd_reg;
    logic                  rd_valid_reg;
    logic                  prod_valid_reg;
    logic signed [32:0]    prod_next [3];
    logic signed [32:0]    prod_reg [3];
    logic signed [ACC_W-1:0] acc_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctrl.pix_we)
        begin
            pix_mem[wr_addr] <= wr_pixel;
        end
        if (ctrl.rd_en)
        begin
            pix_rd_reg <= pix_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (ctrl.rd_en)
        begin
            coef_rd_reg <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= ctrl.rd_en;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic signed [RW-1:0] ref_ext;
        logic signed [RW-1:0] sum;
        logic signed [RW-1:0] rnd;
        logic [QW-1:0]        q;
        logic [QW-16:0]       hi;

        assign prod_next[c] = $signed(pix_rd_reg[PIX_BITS*c +: PIX_BITS])
                            * $signed({1'b0, coef_rd_reg});

        always_ff @(posedge clk)
        begin
            if (rd_valid_reg)
            begin
                prod_reg[c] <= prod_next[c];
            end
            if (ctrl.acc_clear)
            begin
                acc_reg[c] <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
            end
        end

        always_comb
        begin
            ref_ext = RW'($signed({ref_pixel[PIX_BITS*c +: PIX_BITS], 16'h0000}));
            sum     = sub ? (ref_ext - RW'(acc_reg[c])) : RW'(acc_reg[c]);
            rnd     = sum + RW'(32768);
            q       = rnd[RW-1:16];
            hi      = q[QW-1:15];
            if (hi == '0 || hi == '1)
            begin
                result[PIX_BITS*c +: PIX_BITS] = q[15:0];
            end
            else
            begin
                result[PIX_BITS*c +: PIX_BITS] = {q[QW-1], {15{~q[QW-1]}}};
            end
        end
    end

endmodule

>>> sim/tb_upsample_convolve_pixel_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for upsample_convolve_pixel_unit: a directed table, then random
// phases at several image sizes, checked against a behavioral model of the 5x5 convolution.
// Depends on ucp_pkg and the unit's RTL.
module tb_upsample_convolve_pixel_unit;
    import ucp_pkg::*;

    localparam int IMG_MAX = 128;
    localparam int KSIZE = 5;
    localparam int TAPS = KSIZE * KSIZE;
    localparam int ITEMS_TARGET = 1950;
    localparam int CALM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum int {
        KERN_ZERO,
        KERN_FULL,
        KERN_BOX,
        KERN_IMPULSE,
        KERN_SPARSE,
        KERN_RANDOM
    } kernel_kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic [4:0]         cidx;
        logic [15:0]        cval;
        logic               sub;
    } pix_req_t;

    typedef struct packed {
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic               oor;
    } pix_res_t;

    typedef struct packed {
        logic     is_cfg;
        pix_req_t req;
        logic     typed;
        pix_res_t want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_NOP;
    logic [7:0]         col = '0;
    logic [7:0]         row = '0;
    logic signed [15:0] red = '0;
    logic signed [15:0] green = '0;
    logic signed [15:0] blue = '0;
    logic [4:0]         coef_index = '0;
    logic [15:0]        coef_value = '0;
    logic               subtract = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_red;
    logic signed [15:0] out_green;
    logic signed [15:0] out_blue;
    logic               out_of_range;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_WIDTH;
    logic [7:0]         cfg_data = '0;

    logic signed [15:0] pix_red [IMG_MAX * IMG_MAX];
    logic signed [15:0] pix_green [IMG_MAX * IMG_MAX];
    logic signed [15:0] pix_blue [IMG_MAX * IMG_MAX];
    bit                 pix_written [IMG_MAX * IMG_MAX];
    logic [15:0]        kernel [TAPS];
    logic [7:0]         width_reg = 8'd128;
    logic [7:0]         height_reg = 8'd128;
    pix_res_t           pending_results [$];

    int  failures = 0;
    int  items_done = 0;
    int  computes = 0;
    int  oor_hits = 0;
    int  results_seen = 0;
    int  size_settings = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;

    // is_cfg, {kind, col, row, red, green, blue, cidx, cval, sub}, typed, {red, green, blue, oor}
    // A configuration row carries the width in col and the height in row.
    stim_row_t directed_rows [25] = '{
        '{0, '{REQ_PIXEL, 0, 0, 32767, -32768, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 1, 0, -1, 1, 16384, 3, 7, 1}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 0, 1, 21845, -21846, -16384, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 1, 1, 100, -100, 7, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 126, 126, 12345, -12345, 32767, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 127, 126, -32768, 0, 1, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 126, 127, 16383, -16385, -2, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 127, 127, -32768, 32767, -1, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_PIXEL, 255, 255, 1, 1, 1, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COEF, 0, 0, 0, 0, 0, 31, 65535, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COEF, 0, 0, 0, 0, 0, 25, 43690, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_NOP, 85, 170, 21845, -21846, 1, 10, 21845, 1}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 255, 255, 32767, -32768, -1, 0, 0, 1}, 1,
            '{32767, -32768, -1, 0}},
        '{0, '{REQ_COEF, 0, 0, 0, 0, 0, 12, 65535, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COEF, 0, 0, 0, 0, 0, 0, 1, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COEF, 0, 0, 0, 0, 0, 24, 32768, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 255, 254, -32768, 32767, 0, 0, 0, 1}, 0, '{0, 0, 0, 0}},
        '{1, '{REQ_NOP, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 2, 0, 500, 600, 700, 0, 0, 0}, 1, '{0, 0, 0, 1}},
        '{0, '{REQ_COMPUTE, 0, 3, 32767, 32767, 32767, 0, 0, 1}, 1, '{0, 0, 0, 1}},
        '{0, '{REQ_COMPUTE, 1, 1, -32768, -32768, 32767, 0, 0, 1}, 0, '{0, 0, 0, 0}},
        '{1, '{REQ_NOP, 255, 255, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}},
        '{0, '{REQ_COMPUTE, 254, 255, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0}}
    };

    upsample_convolve_pixel_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .col          (col),
        .row          (row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .subtract     (subtract),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int eff_dim(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (v > IMG_MAX)
            return IMG_MAX;
        return int'(v);
    endfunction

    function automatic bit fallback_off(input int c, input int r);
        return (c >> 1) >= eff_dim(width_reg) || (r >> 1) >= eff_dim(height_reg);
    endfunction

    function automatic int tap_addr(input int c, input int r, input int x, input int y);
        int sx;
        int sy;
        sx = c - KSIZE / 2 + x;
        sy = r - KSIZE / 2 + y;
        if (sx >= 0 && sy >= 0 && (sx >> 1) < eff_dim(width_reg)
            && (sy >> 1) < eff_dim(height_reg))
            return (sy >> 1) * IMG_MAX + (sx >> 1);
        return (r >> 1) * IMG_MAX + (c >> 1);
    endfunction

    function automatic bit reads_written(input int c, input int r);
        if (fallback_off(c, r))
            return 1'b1;
        for (int y = 0; y < KSIZE; y++)
            for (int x = 0; x < KSIZE; x++)
                if (!pix_written[tap_addr(c, r, x, y)])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] round_q214(input longint v);
        longint q;
        q = (v + 64'sd32768) >>> 16;
        if (q > 32767)
            return 16'sd32767;
        if (q < -32768)
            return -16'sd32768;
        return q[15:0];
    endfunction

    function automatic bit predict_pixel(input pix_req_t q, output pix_res_t res);
        int     a;
        longint k;
        longint acc_r;
        longint acc_g;
        longint acc_b;
        res = '0;
        if (q.kind == REQ_PIXEL)
        begin
            if (q.col < eff_dim(width_reg) && q.row < eff_dim(height_reg))
            begin
                a = int'(q.row) * IMG_MAX + int'(q.col);
                pix_red[a] = q.red;
                pix_green[a] = q.green;
                pix_blue[a] = q.blue;
                pix_written[a] = 1'b1;
            end
            return 1'b0;
        end
        if (q.kind == REQ_COEF)
        begin
            if (q.cidx < TAPS)
            begin
                kernel[q.cidx] = q.cval;
            end
            return 1'b0;
        end
        if (q.kind != REQ_COMPUTE)
            return 1'b0;
        if (fallback_off(q.col, q.row))
        begin
            res.oor = 1'b1;
            return 1'b1;
        end
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int y = 0; y < KSIZE; y++)
        begin
            for (int x = 0; x < KSIZE; x++)
            begin
                a = tap_addr(q.col, q.row, x, y);
                k = longint'(kernel[y * KSIZE + x]);
                acc_r += longint'(pix_red[a]) * k;
                acc_g += longint'(pix_green[a]) * k;
                acc_b += longint'(pix_blue[a]) * k;
            end
        end
        if (q.sub)
        begin
            acc_r = longint'($signed(q.red)) * 65536 - acc_r;
            acc_g = longint'($signed(q.green)) * 65536 - acc_g;
            acc_b = longint'($signed(q.blue)) * 65536 - acc_b;
        end
        res.red = round_q214(acc_r);
        res.green = round_q214(acc_g);
        res.blue = round_q214(acc_b);
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pix_req_t random_req(input logic [1:0] kind);
        pix_req_t q;
        q.kind = kind;
        q.col = 8'($urandom);
        q.row = 8'($urandom);
        q.red = rand_sample();
        q.green = rand_sample();
        q.blue = rand_sample();
        q.cidx = 5'($urandom);
        q.cval = 16'($urandom);
        q.sub = 1'($urandom);
        return q;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic issue(input pix_req_t q, input bit given, input pix_res_t want);
        pix_res_t predicted;
        bit       has_result;
        req_type <= q.kind;
        col <= q.col;
        row <= q.row;
        red <= q.red;
        green <= q.green;
        blue <= q.blue;
        coef_index <= q.cidx;
        coef_value <= q.cval;
        subtract <= q.sub;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        has_result = predict_pixel(q, predicted);
        items_done++;
        if (has_result)
        begin
            pending_results.push_back(given ? want : predicted);
            computes++;
            if (predicted.oor)
                oor_hits++;
        end
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input logic [7:0] w, input logic [7:0] h);
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        width_reg = w;
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        do @(posedge clk); while (!cfg_ready);
        height_reg = h;
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    task automatic load_kernel(input kernel_kind_t kind);
        pix_req_t q;
        for (int i = 0; i < TAPS; i++)
        begin
            q = random_req(REQ_COEF);
            q.cidx = 5'(i);
            case (kind)
                KERN_ZERO: q.cval = 16'd0;
                KERN_FULL: q.cval = 16'hFFFF;
                KERN_BOX: q.cval = 16'(2600 + $urandom_range(0, 40));
                KERN_IMPULSE: q.cval = (i == TAPS / 2) ? 16'hFFFF : 16'd0;
                KERN_SPARSE: q.cval = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
                default: q.cval = 16'($urandom);
            endcase
            issue(q, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        pix_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_red", $signed(want.red), out_red);
                check_field("out_green", $signed(want.green), out_green);
                check_field("out_blue", $signed(want.blue), out_blue);
                check_field("out_of_range", want.oor, out_of_range);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        pix_req_t q;
        int       w_eff;
        int       h_eff;
        int       bw;
        int       bh;
        int       bx0;
        int       by0;
        int       c_lo;
        int       c_hi;
        int       r_lo;
        int       r_hi;
        int       tries;
        int       phase_count;
        int       i;
        phase_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_kernel(KERN_ZERO);
        for (i = 0; i < $size(directed_rows); i++)
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle_idle();
                set_size(directed_rows[i].req.col, directed_rows[i].req.row);
            end
            else
                issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        while (items_done < ITEMS_TARGET)
        begin
            settle_idle();
            case ($urandom_range(0, 6))
                0: set_size(8'd0, 8'd0);
                1: set_size(8'd1, 8'($urandom_range(1, 16)));
                2: set_size(8'd128, 8'd128);
                3: set_size(8'd255, 8'($urandom_range(129, 255)));
                4: set_size(8'($urandom), 8'($urandom));
                default: set_size(8'($urandom_range(2, 10)), 8'($urandom_range(2, 10)));
            endcase
            w_eff = eff_dim(width_reg);
            h_eff = eff_dim(height_reg);
            bw = (w_eff < 8) ? w_eff : 8;
            bh = (h_eff < 8) ? h_eff : 8;
            bx0 = $urandom_range(0, w_eff - bw);
            by0 = $urandom_range(0, h_eff - bh);
            c_lo = (2 * bx0 - 4 < 0) ? 0 : 2 * bx0 - 4;
            c_hi = (2 * (bx0 + bw) + 3 > 255) ? 255 : 2 * (bx0 + bw) + 3;
            r_lo = (2 * by0 - 4 < 0) ? 0 : 2 * by0 - 4;
            r_hi = (2 * (by0 + bh) + 3 > 255) ? 255 : 2 * (by0 + bh) + 3;
            load_kernel(kernel_kind_t'($urandom_range(0, 5)));
            for (int y = by0; y < by0 + bh; y++)
            begin
                for (int x = bx0; x < bx0 + bw; x++)
                begin
                    q = random_req(REQ_PIXEL);
                    q.col = 8'(x);
                    q.row = 8'(y);
                    issue(q, 1'b0, '0);
                end
            end
            if (phase_count == 1)
                hold_request = 1'b1;
            repeat ($urandom_range(80, 200))
            begin
                if (items_done >= ITEMS_TARGET)
                    break;
                if (items_done >= ITEMS_TARGET - CALM_ITEMS)
                    calm = 1'b1;
                case ($urandom_range(0, 19))
                    0: q = random_req(REQ_NOP);
                    1, 2: q = random_req(REQ_COEF);
                    3, 4, 5, 6:
                    begin
                        q = random_req(REQ_PIXEL);
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                if ($urandom_range(0, 1))
                                    q.col = 8'($urandom_range(w_eff, 255));
                                else
                                    q.row = 8'($urandom_range(h_eff, 255));
                            end
                            1:
                            begin
                                q.col = 8'($urandom_range(0, w_eff - 1));
                                q.row = 8'($urandom_range(0, h_eff - 1));
                            end
                            default:
                            begin
                                q.col = 8'($urandom_range(bx0, bx0 + bw - 1));
                                q.row = 8'($urandom_range(by0, by0 + bh - 1));
                            end
                        endcase
                    end
                    default:
                    begin
                        q = random_req(REQ_COMPUTE);
                        tries = 0;
                        do
                        begin
                            q.col = 8'($urandom_range(c_lo, c_hi));
                            q.row = 8'($urandom_range(r_lo, r_hi));
                            tries++;
                        end
                        while (!reads_written(q.col, q.row) && tries < 20);
                        if (!reads_written(q.col, q.row))
                        begin
                            q.kind = REQ_PIXEL;
                            q.col = 8'(bx0);
                            q.row = 8'(by0);
                        end
                    end
                endcase
                issue(q, 1'b0, '0);
            end
            phase_count++;
        end

        settle_idle();
        $display("Covered %0d requests, %0d computes of which %0d fell off the image,",
                 items_done, computes, oor_hits);
        $display("across %0d size settings, with %0d results checked.",
                 size_settings, results_seen);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
